[rtl/first_match_rule_selector_assert.svh]
// ----------------------------------------------------------------------------
// first_match_rule_selector_assert.svh
// assertion macros for the rule selector, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_RULE_SELECTOR_ASSERT_SVH
`define FIRST_MATCH_RULE_SELECTOR_ASSERT_SVH

// condition holds in the same cycle
`define FMRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define FMRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fmrs_pkg.sv]
// ----------------------------------------------------------------------------
// fmrs_pkg
// types, constants and the per-rule match function of the rule selector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmrs_pkg;

    localparam int MAX_OPERANDS = 4;
    localparam int OPCODE_W     = 8;
    localparam int LEN_W        = 3;
    localparam int KIND_W       = 6;
    localparam int CODE_W       = 3;
    localparam int SIZE_W       = 4;
    localparam int ID_W         = 16;
    localparam int MASKS_W      = MAX_OPERANDS * KIND_W;
    localparam int CODES_W      = MAX_OPERANDS * CODE_W;
    localparam int SIZES_W      = MAX_OPERANDS * SIZE_W;

    localparam logic [CODE_W-1:0] LAST_KIND_CODE = 3'd5;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [LEN_W-1:0]    kind_len;
        logic [LEN_W-1:0]    size_len;
        logic [MASKS_W-1:0]  masks;
        logic [SIZES_W-1:0]  sizes;
        logic [ID_W-1:0]     id;
    } rule_t;

    // query travelling down the cell row
    typedef struct packed {
        logic                active;
        logic [OPCODE_W-1:0] opcode;
        logic [LEN_W-1:0]    cnt;
        logic [CODES_W-1:0]  codes;
        logic [SIZES_W-1:0]  sizes;
        logic                found;
        logic [ID_W-1:0]     id;
    } token_t;

    function automatic logic rule_hits(rule_t r, token_t t);
        logic               ok;
        logic [7:0]         mext;
        logic [CODE_W-1:0]  code;
        ok = (r.opcode == t.opcode);
        if (r.kind_len != '0 && (r.kind_len != t.cnt || t.cnt > MAX_OPERANDS))
        begin
            ok = 1'b0;
        end
        if (r.size_len != '0 && (r.size_len != t.cnt || t.cnt > MAX_OPERANDS))
        begin
            ok = 1'b0;
        end
        for (int i = 0; i < MAX_OPERANDS; i++)
        begin
            code = t.codes[i*CODE_W +: CODE_W];
            mext = {{(8-KIND_W){1'b0}}, r.masks[i*KIND_W +: KIND_W]};
            if (r.kind_len != '0 && i < t.cnt)
            begin
                if (code > LAST_KIND_CODE || !mext[code])
                begin
                    ok = 1'b0;
                end
            end
            if (r.size_len != '0 && i < t.cnt)
            begin
                if (t.sizes[i*SIZE_W +: SIZE_W] != r.sizes[i*SIZE_W +: SIZE_W])
                begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

[rtl/fmrs_in_if.sv]
// ----------------------------------------------------------------------------
// fmrs_in_if
// command channel: rule adds and queries
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fmrs_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [fmrs_pkg::OPCODE_W-1:0]     opcode;
    logic [fmrs_pkg::LEN_W-1:0]        operand_count;
    logic [fmrs_pkg::LEN_W-1:0]        kind_len;
    logic [fmrs_pkg::LEN_W-1:0]        size_len;
    logic [fmrs_pkg::MASKS_W-1:0]      kind_masks;
    logic [fmrs_pkg::CODES_W-1:0]      kind_codes;
    logic [fmrs_pkg::SIZES_W-1:0]      operand_sizes;
    logic [fmrs_pkg::ID_W-1:0]         target_id;

    modport source (
        output valid, func, opcode, operand_count, kind_len, size_len,
               kind_masks, kind_codes, operand_sizes, target_id,
        input  ready
    );

    modport sink (
        input  valid, func, opcode, operand_count, kind_len, size_len,
               kind_masks, kind_codes, operand_sizes, target_id,
        output ready
    );
endinterface

[rtl/fmrs_out_if.sv]
// ----------------------------------------------------------------------------
// fmrs_out_if
// result channel: selected id and status flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fmrs_out_if;
    logic                          valid;
    logic                          ready;
    logic [fmrs_pkg::ID_W-1:0]     selected_id;
    logic                          matched;
    logic                          rejected;

    modport source (
        output valid, selected_id, matched, rejected,
        input  ready
    );

    modport sink (
        input  valid, selected_id, matched, rejected,
        output ready
    );
endinterface

[rtl/first_match_rule_selector.sv]
// ----------------------------------------------------------------------------
// first_match_rule_selector
// insertion-ordered rule table with a first-match query running down a row
// of rule cells
// ----------------------------------------------------------------------------
//  channel  dir  modport  payload
//  cmd      in   sink     func, opcode, operand_count, kind_len, size_len,
//                         kind_masks, kind_codes, operand_sizes, target_id
//  res      out  source   selected_id, matched, rejected
//
//  one item at a time; cmd.ready is high only in idle, while the result of
//  the previous item may still wait at res
//  an add is written into the slot named by the fill count; its status goes
//  through the hold register to the output register
//  a query walks the cell row one slot per cycle, then passes the hold register
//  and the output register; reset empties the table at once (per-slot valid
//  bits), with no clearing pass; a result waits in a hold register while res is
//  stalled, the output register and the hold stage part the two sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_match_rule_selector #(
    parameter int RULE_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    fmrs_in_if.sink     cmd,
    fmrs_out_if.source  res
);

`include "first_match_rule_selector_assert.svh"

    localparam int FILL_W = $clog2(RULE_SLOTS + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RULE_SLOTS);

    fmrs_pkg::state_t  state_reg;
    fmrs_pkg::state_t  state_next;
    logic [FILL_W-1:0] fill_reg;
    logic              full;
    logic              accept;
    logic              add_ok;
    logic              out_free;
    logic              load_add;
    logic              load_query;
    logic              load_out;

    logic [fmrs_pkg::ID_W-1:0] hold_id_reg;
    logic                      hold_matched_reg;
    logic                      hold_rejected_reg;
    logic                      out_valid_reg;
    logic [fmrs_pkg::ID_W-1:0] out_id_reg;
    logic                      out_matched_reg;
    logic                      out_rejected_reg;

    fmrs_pkg::rule_t   wr_rule;
    fmrs_pkg::token_t  tok [0:RULE_SLOTS];
    logic [RULE_SLOTS-1:0] active_vec;

    assign full     = (fill_reg == FILL_FULL);
    assign accept   = cmd.valid && cmd.ready;
    assign add_ok   = accept && (cmd.func == fmrs_pkg::FUNC_ADD) && !full;
    assign out_free = !out_valid_reg || res.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fmrs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == fmrs_pkg::FUNC_SELECT)
                    begin
                        state_next = fmrs_pkg::ST_RUN;
                    end
                    else
                    begin
                        state_next = fmrs_pkg::ST_HOLD;
                    end
                end
            end
            fmrs_pkg::ST_RUN:
            begin
                if (tok[RULE_SLOTS].active)
                begin
                    state_next = fmrs_pkg::ST_HOLD;
                end
            end
            fmrs_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = fmrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fmrs_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd.ready  = 1'b0;
        load_add   = 1'b0;
        load_query = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            fmrs_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                load_add  = cmd.valid && (cmd.func == fmrs_pkg::FUNC_ADD);
            end
            fmrs_pkg::ST_RUN:
            begin
                load_query = tok[RULE_SLOTS].active;
            end
            fmrs_pkg::ST_HOLD:
            begin
                load_out = out_free;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmrs_pkg::ST_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (add_ok)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_add)
        begin
            hold_id_reg       <= '0;
            hold_matched_reg  <= 1'b0;
            hold_rejected_reg <= full;
        end
        else if (load_query)
        begin
            hold_id_reg       <= tok[RULE_SLOTS].found ? tok[RULE_SLOTS].id : '0;
            hold_matched_reg  <= tok[RULE_SLOTS].found;
            hold_rejected_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_id_reg       <= hold_id_reg;
            out_matched_reg  <= hold_matched_reg;
            out_rejected_reg <= hold_rejected_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.selected_id = out_id_reg;
    assign res.matched     = out_matched_reg;
    assign res.rejected    = out_rejected_reg;

    assign wr_rule.opcode   = cmd.opcode;
    assign wr_rule.kind_len = cmd.kind_len;
    assign wr_rule.size_len = cmd.size_len;
    assign wr_rule.masks    = cmd.kind_masks;
    assign wr_rule.sizes    = cmd.operand_sizes;
    assign wr_rule.id       = cmd.target_id;

    // query enters the head of the row
    assign tok[0] = '{active: accept && (cmd.func == fmrs_pkg::FUNC_SELECT),
                      opcode: cmd.opcode,
                      cnt:    cmd.operand_count,
                      codes:  cmd.kind_codes,
                      sizes:  cmd.operand_sizes,
                      found:  1'b0,
                      id:     '0};

    for (genvar g = 0; g < RULE_SLOTS; g++)
    begin : g_cell
        fmrs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (add_ok && (fill_reg == FILL_W'(g))),
            .wr_rule (wr_rule),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
        assign active_vec[g] = tok[g+1].active;
    end

    `FMRS_ASSERT_IMP(a_fill_range, 1'b1, fill_reg <= FILL_FULL, "fill count past table size")
    `FMRS_ASSERT_IMP(a_one_query, 1'b1, $countones(active_vec) <= 1, "two queries in the row")
    `FMRS_ASSERT_IMP(a_row_busy, active_vec != '0, state_reg == fmrs_pkg::ST_RUN,
        "query in the row outside run state")
    `FMRS_ASSERT_NXT(a_full_reject, load_add && full, hold_rejected_reg,
        "add on a full table not rejected")

endmodule

[rtl/fmrs_cell.sv]
// ----------------------------------------------------------------------------
// fmrs_cell
// one rule slot: holds a rule and checks the passing query against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmrs_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  fmrs_pkg::rule_t   wr_rule,
    input  fmrs_pkg::token_t  tok_in,
    output fmrs_pkg::token_t  tok_out
);

    fmrs_pkg::rule_t   rule_reg;
    logic              valid_reg;
    fmrs_pkg::token_t  tok_reg;
    fmrs_pkg::token_t  tok_next;
    logic              hit;

    assign hit = valid_reg && fmrs_pkg::rule_hits(rule_reg, tok_in);

    // an earlier cell's match always wins
    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.found && hit)
        begin
            tok_next.found = 1'b1;
            tok_next.id    = rule_reg.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_reg <= wr_rule;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
